// ----- design/pavm_pkg.sv -----
// Shared constants, types and controller/datapath command structs for the
// polygon area and vertex mean unit. No dependencies.
package pavm_pkg;

   localparam int COORD_W          = 16;
   localparam int AREA_W           = 43;
   localparam int PROD_W           = 2 * COORD_W;
   localparam int MAX_VERTICES_DEF = 1024;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [AREA_W-1:0]  area_type;

   typedef enum logic [1:0] {
      PROD_NONE,
      PROD_VERTEX,
      PROD_CLOSE
   } prod_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic         load_vertex;
      prod_sel_type prod_sel;
      logic         div_load;
      logic         div_step;
      logic         rsp_load;
      logic         clear;
   } dp_cmd_type;

   typedef struct packed {
      logic div_last;
   } dp_status_type;

endpackage

// ----- design/pavm_vertex_if.sv -----
// Request channel carrying one polygon vertex.
// Depends on pavm_pkg.
interface pavm_vertex_if;
   logic                 valid;
   logic                 ready;
   pavm_pkg::coord_type  x_coord;
   pavm_pkg::coord_type  y_coord;
   logic                 last_vertex;

   modport source (output valid, x_coord, y_coord, last_vertex, input ready);
   modport sink   (input valid, x_coord, y_coord, last_vertex, output ready);
endinterface

// ----- design/pavm_result_if.sv -----
// Response channel carrying the area and vertex mean of one polygon.
// Depends on pavm_pkg.
interface pavm_result_if;
   logic                 valid;
   logic                 ready;
   pavm_pkg::area_type   area_times_two;
   pavm_pkg::coord_type  center_x;
   pavm_pkg::coord_type  center_y;
   logic                 overflow;

   modport source (output valid, area_times_two, center_x, center_y, overflow,
                   input ready);
   modport sink   (input valid, area_times_two, center_x, center_y, overflow,
                   output ready);
endinterface

// ----- design/pavm_dp.sv -----
// Datapath: vertex accumulators, cross product multipliers, a two-lane
// restoring divider for the mean and the response payload register. Uses pavm_pkg.
module pavm_dp #(
   parameter int MAX_VERTICES = pavm_pkg::MAX_VERTICES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pavm_pkg::dp_cmd_type    cmd,
   output pavm_pkg::dp_status_type status,
   input  pavm_pkg::coord_type     req_x,
   input  pavm_pkg::coord_type     req_y,
   output pavm_pkg::area_type      rsp_area,
   output pavm_pkg::coord_type     rsp_center_x,
   output pavm_pkg::coord_type     rsp_center_y,
   output logic                    rsp_overflow
);

   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int SUM_W  = pavm_pkg::COORD_W + CNT_W;
   localparam int ITER_W = $clog2(SUM_W + 1);
   localparam int PROD_W = pavm_pkg::PROD_W;
   localparam int AREA_W = pavm_pkg::AREA_W;
   localparam int COORD_W = pavm_pkg::COORD_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

   pavm_pkg::coord_type      first_x_ff, first_x_in, first_y_ff, first_y_in;
   pavm_pkg::coord_type      prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [AREA_W-1:0] cross_sum_ff, cross_sum_in;
   logic signed [SUM_W-1:0]  sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     ovf_ff, ovf_in;
   logic signed [PROD_W-1:0] prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic signed [PROD_W:0]   prod_diff;

   logic [SUM_W-1:0]         quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic [CNT_W-1:0]         rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic                     neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic [SUM_W-1:0]         mean_x, mean_y;

   pavm_pkg::area_type       area_ff, area_in;
   pavm_pkg::coord_type      cx_ff, cx_in, cy_ff, cy_in;
   logic                     rovf_ff, rovf_in;

   logic                     full, take;

   // One restoring step: shift the next dividend bit into the remainder and
   // subtract the divisor when it fits, shifting the quotient bit in below.
   function automatic logic [CNT_W+SUM_W-1:0] div_step_f(
      input logic [CNT_W-1:0] rem,
      input logic [SUM_W-1:0] quo,
      input logic [CNT_W-1:0] den
   );
      logic [CNT_W:0] trial;
      logic           qbit;
      trial = {rem, quo[SUM_W-1]};
      qbit  = 1'b0;
      if (trial >= {1'b0, den}) begin
         trial = trial - {1'b0, den};
         qbit  = 1'b1;
      end
      return {trial[CNT_W-1:0], quo[SUM_W-2:0], qbit};
   endfunction

   assign full = (count_ff == CNT_MAX);
   assign take = cmd.load_vertex && !full;

   always_comb begin
      prod_a_in = '0;
      prod_b_in = '0;
      unique case (cmd.prod_sel)
         pavm_pkg::PROD_VERTEX: begin
            if (take && (count_ff != '0)) begin
               prod_a_in = prev_x_ff * req_y;
               prod_b_in = prev_y_ff * req_x;
            end
         end
         pavm_pkg::PROD_CLOSE: begin
            prod_a_in = prev_x_ff * first_y_ff;
            prod_b_in = prev_y_ff * first_x_ff;
         end
         default: begin
         end
      endcase
   end

   // Products registered last cycle are folded in here; idle cycles add zero.
   assign prod_diff = {prod_a_ff[PROD_W-1], prod_a_ff} - {prod_b_ff[PROD_W-1], prod_b_ff};

   always_comb begin
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      cross_sum_in = cross_sum_ff + AREA_W'(prod_diff);
      if (cmd.clear) begin
         first_x_in   = '0;
         first_y_in   = '0;
         prev_x_in    = '0;
         prev_y_in    = '0;
         sum_x_in     = '0;
         sum_y_in     = '0;
         count_in     = '0;
         ovf_in       = 1'b0;
         cross_sum_in = '0;
      end else if (cmd.load_vertex) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            if (count_ff == '0) begin
               first_x_in = req_x;
               first_y_in = req_y;
            end
            prev_x_in = req_x;
            prev_y_in = req_y;
            sum_x_in  = sum_x_ff + SUM_W'(req_x);
            sum_y_in  = sum_y_ff + SUM_W'(req_y);
            count_in  = count_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      quo_x_in = quo_x_ff;
      quo_y_in = quo_y_ff;
      rem_x_in = rem_x_ff;
      rem_y_in = rem_y_ff;
      neg_x_in = neg_x_ff;
      neg_y_in = neg_y_ff;
      iter_in  = iter_ff;
      if (cmd.div_load) begin
         quo_x_in = sum_x_ff[SUM_W-1] ? SUM_W'(-sum_x_ff) : SUM_W'(sum_x_ff);
         quo_y_in = sum_y_ff[SUM_W-1] ? SUM_W'(-sum_y_ff) : SUM_W'(sum_y_ff);
         rem_x_in = '0;
         rem_y_in = '0;
         neg_x_in = sum_x_ff[SUM_W-1];
         neg_y_in = sum_y_ff[SUM_W-1];
         iter_in  = ITER_W'(SUM_W);
      end else if (cmd.div_step) begin
         {rem_x_in, quo_x_in} = div_step_f(rem_x_ff, quo_x_ff, count_ff);
         {rem_y_in, quo_y_in} = div_step_f(rem_y_ff, quo_y_ff, count_ff);
         iter_in = iter_ff - ITER_W'(1);
      end
   end

   assign status.div_last = (iter_ff == ITER_W'(1));

   assign mean_x = neg_x_ff ? (~quo_x_ff + SUM_W'(1)) : quo_x_ff;
   assign mean_y = neg_y_ff ? (~quo_y_ff + SUM_W'(1)) : quo_y_ff;

   always_comb begin
      area_in = area_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      rovf_in = rovf_ff;
      if (cmd.rsp_load) begin
         area_in = cross_sum_ff;
         cx_in   = mean_x[COORD_W-1:0];
         cy_in   = mean_y[COORD_W-1:0];
         rovf_in = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         cross_sum_ff <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         prod_a_ff    <= '0;
         prod_b_ff    <= '0;
         iter_ff      <= '0;
      end else begin
         first_x_ff   <= first_x_in;
         first_y_ff   <= first_y_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         cross_sum_ff <= cross_sum_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         prod_a_ff    <= prod_a_in;
         prod_b_ff    <= prod_b_in;
         iter_ff      <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_x_ff <= quo_x_in;
      quo_y_ff <= quo_y_in;
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
      area_ff  <= area_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      rovf_ff  <= rovf_in;
   end

   assign rsp_area     = area_ff;
   assign rsp_center_x = cx_ff;
   assign rsp_center_y = cy_ff;
   assign rsp_overflow = rovf_ff;

endmodule

// ----- design/pavm_ctrl.sv -----
// Controller state machine: request and response handshakes and the
// command sequence for the datapath. Uses pavm_pkg.
module pavm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  pavm_pkg::dp_status_type status,
   output pavm_pkg::dp_cmd_type    cmd
);

   pavm_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pavm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      req_ready        = 1'b0;
      cmd.load_vertex  = 1'b0;
      cmd.prod_sel     = pavm_pkg::PROD_NONE;
      cmd.div_load     = 1'b0;
      cmd.div_step     = 1'b0;
      cmd.rsp_load     = 1'b0;
      cmd.clear        = 1'b0;
      unique case (state_ff)
         pavm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_vertex = 1'b1;
               cmd.prod_sel    = pavm_pkg::PROD_VERTEX;
               if (req_last) begin
                  state_in = pavm_pkg::ST_CLOSE;
               end
            end
         end
         pavm_pkg::ST_CLOSE: begin
            // Sums are final here, so the divider can start while the
            // closing cross product is formed.
            cmd.prod_sel = pavm_pkg::PROD_CLOSE;
            cmd.div_load = 1'b1;
            state_in     = pavm_pkg::ST_DIV;
         end
         pavm_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = pavm_pkg::ST_DONE;
            end
         end
         pavm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = pavm_pkg::ST_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

endmodule

// ----- design/polygon_area_and_vertex_mean_unit.sv -----
// Top level of the shoelace polygon area and vertex mean unit.
// Depends on pavm_pkg, pavm_vertex_if, pavm_result_if, pavm_ctrl and pavm_dp.
//
//   channel   direction  payload
//   req_chan  in         x_coord, y_coord, last_vertex (one vertex per request)
//   rsp_chan  out        area_times_two, center_x, center_y, overflow
//
// A vertex without the last flag is taken back to back. After the last
// vertex the unit closes the ring (ST_CLOSE), runs the restoring divider
// over SUM_W = 16 + clog2(MAX_VERTICES+1) quotient bits (one quotient bit
// per cycle, both axes at once, ST_DIV), then loads the response (ST_DONE)
// before it takes the next request.
// Reset is synchronous and clears all accumulators. The response sits in an
// output register; if the previous one is still not taken, the unit waits.
module polygon_area_and_vertex_mean_unit #(
   parameter int MAX_VERTICES = pavm_pkg::MAX_VERTICES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   pavm_vertex_if.sink   req_chan,
   pavm_result_if.source rsp_chan
);

   pavm_pkg::dp_cmd_type    cmd;
   pavm_pkg::dp_status_type status;

   pavm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_vertex),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pavm_dp #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_x        (req_chan.x_coord),
      .req_y        (req_chan.y_coord),
      .rsp_area     (rsp_chan.area_times_two),
      .rsp_center_x (rsp_chan.center_x),
      .rsp_center_y (rsp_chan.center_y),
      .rsp_overflow (rsp_chan.overflow)
   );

endmodule
